// File: rtl/sha_pkg.sv
// sha-256 engine package: word types, round constants, initial hash values
// and the final-word padding function; no dependencies
package sha_pkg;

    typedef logic [31:0] t_word;

    // round controller state shared by the schedule and the top level
    typedef struct packed {
        logic       active;
        logic [1:0] phase;
        logic [5:0] t;
    } t_rnd_ctl;

    localparam int RoundCount = 64;
    localparam int HashWords  = 8;
    localparam logic [1:0] PhaseRead  = 2'd0;
    localparam logic [1:0] PhaseSigma = 2'd1;
    localparam logic [1:0] PhaseWord  = 2'd2;
    localparam logic [1:0] PhaseRound = 2'd3;

    localparam t_word MarkerWord = 32'h8000_0000;

    localparam t_word RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word InitH [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // short final word: keep the valid bytes and place the marker after them
    function automatic t_word pad_word(input t_word data, input logic [2:0] count);
        t_word res;
        unique case (count)
            3'd1:    res = (data & 32'hff00_0000) | 32'h0080_0000;
            3'd2:    res = (data & 32'hffff_0000) | 32'h0000_8000;
            3'd3:    res = (data & 32'hffff_ff00) | 32'h0000_0080;
            default: res = MarkerWord;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/sha_sched.sv
// message schedule: 16-entry window memory with two registered read ports
// and the sigma expansion; depends on sha_pkg
module sha_sched
    import sha_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_ld_we,
    input  logic [3:0] i_ld_addr,
    input  t_word    i_ld_data,
    input  t_rnd_ctl i_ctl,
    output t_word    o_w
);

    t_word      mem [16];
    t_word      r_qa;
    t_word      r_qb;
    t_word      r_s0;
    t_word      r_s1;
    t_word      r_w;
    t_word      n_w;
    logic [3:0] ra;
    logic [3:0] rb;
    logic [3:0] ti;

    assign ti = i_ctl.t[3:0];

    // read addresses per phase
    always_comb begin
        if (i_ctl.phase == PhaseRead) begin
            ra = ti - 4'd2;
            rb = ti - 4'd15;
        end else begin
            ra = ti - 4'd7;
            rb = ti;
        end
    end

    // new schedule word, or the stored one in the first sixteen rounds
    always_comb begin
        if (i_ctl.t < 6'd16) begin
            n_w = r_qb;
        end else begin
            n_w = r_s1 + r_qa + r_s0 + r_qb;
        end
    end

    // memory: loader write, expansion write-back, two synchronous reads
    always_ff @(posedge i_clk) begin
        if (i_ld_we) begin
            mem[i_ld_addr] <= i_ld_data;
        end else if (i_ctl.active && i_ctl.phase == PhaseWord && i_ctl.t >= 6'd16) begin
            mem[ti] <= n_w;
        end
        r_qa <= mem[ra];
        r_qb <= mem[rb];
    end

    // sigma terms and the word register
    always_ff @(posedge i_clk) begin
        if (i_ctl.phase == PhaseSigma) begin
            r_s1 <= {r_qa[16:0], r_qa[31:17]} ^ {r_qa[18:0], r_qa[31:19]} ^ (r_qa >> 10);
            r_s0 <= {r_qb[6:0], r_qb[31:7]} ^ {r_qb[17:0], r_qb[31:18]} ^ (r_qb >> 3);
        end
        if (i_ctl.phase == PhaseWord) begin
            r_w <= n_w;
        end
    end

    assign o_w = r_w;

endmodule

// File: rtl/sha_round.sv
// compression round: working variables a..h and one round per step
// depends on sha_pkg
module sha_round
    import sha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_init,
    input  logic  i_step,
    input  t_word i_hash [HashWords],
    input  t_word i_k,
    input  t_word i_w,
    output t_word o_vars [HashWords]
);

    t_word r_v [HashWords];
    t_word t1;
    t_word t2;
    t_word sig1;
    t_word sig0;

    // round functions
    always_comb begin
        sig1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
             ^ {r_v[4][24:0], r_v[4][31:25]};
        sig0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
             ^ {r_v[0][21:0], r_v[0][31:22]};
        t1 = r_v[7] + sig1 + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + i_k + i_w;
        t2 = sig0 + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // load from the hash state or shift the variables
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_v <= i_hash;
        end else if (i_step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_vars = r_v;

endmodule

// File: rtl/sha256_hash_engine_top.sv
// sha-256 engine top level: input handshake, padding sequencer, round
// control, hash state and digest output; depends on sha_pkg, sha_sched, sha_round
//
// usage:
// - input channel (i_valid, o_stall, i_data_word, i_byte_count, i_last_word)
//   carries message words, first byte in bits 31..24; a transaction with
//   i_last_word high ends the message and may hold zero to four bytes
// - output channel (o_valid, i_stall, o_digest_word, o_digest_index,
//   o_digest_last) gives the eight digest words H0..H7 after each message
// - a word that does not fill a block is only written to the schedule memory;
//   the sixteenth word of a block starts compression: 64 rounds, each through
//   two schedule memory reads, sigma, word write-back and the round, then a
//   fold of the working variables into the hash
// - after the last word the padding words go in at one per cycle, with one
//   or two compressions, then the digest words follow one per transaction
// - o_stall is high whenever the engine is not waiting for a word
// - while i_stall is high the current digest word holds; the next message
//   is taken only after the eighth digest word has been taken
// - reset loads the initial hash values and clears the length and position
module sha256_hash_engine_top
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    typedef enum logic [4:0] {
        S_IN  = 5'b00001,
        S_PAD = 5'b00010,
        S_RND = 5'b00100,
        S_FIN = 5'b01000,
        S_OUT = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        K_MARK = 2'd0,
        K_ZERO = 2'd1,
        K_LHI  = 2'd2,
        K_LLO  = 2'd3
    } t_kind;

    t_state     r_state, n_state;
    t_kind      r_kind, n_kind;
    logic [3:0] r_pos, n_pos;
    logic [63:0] r_bits, n_bits;
    logic       r_msg_end, n_msg_end;
    logic       r_len_done, n_len_done;
    logic [2:0] r_oidx, n_oidx;
    t_rnd_ctl   r_ctl, n_ctl;
    t_word      r_h [HashWords];
    t_word      n_h [HashWords];
    t_word      vars [HashWords];
    t_word      w;
    logic       ld_we;
    t_word      ld_data;
    logic       go;
    logic       accept_in;
    logic [2:0] cnt;
    logic [3:0] pos_inc;
    t_kind      fill_kind;

    assign o_stall   = (r_state != S_IN);
    assign accept_in = i_valid && !o_stall;
    assign cnt       = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign pos_inc   = r_pos + 4'd1;
    assign fill_kind = (pos_inc == 4'd14) ? K_LHI : K_ZERO;

    // next-state logic: loading, padding, rounds, hash fold, output
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_bits     = r_bits;
        n_msg_end  = r_msg_end;
        n_len_done = r_len_done;
        n_oidx     = r_oidx;
        n_ctl      = r_ctl;
        n_h        = r_h;
        ld_we      = 1'b0;
        ld_data    = i_data_word;
        go         = 1'b0;
        unique case (r_state)
            S_IN: begin
                if (accept_in) begin
                    ld_we = 1'b1;
                    n_pos = pos_inc;
                    if (!i_last_word) begin
                        n_bits = r_bits + 64'd32;
                        go     = (r_pos == 4'd15);
                    end else begin
                        n_bits    = r_bits + {58'd0, cnt, 3'b000};
                        n_msg_end = 1'b1;
                        if (cnt == 3'd4) begin
                            n_kind = K_MARK;
                        end else begin
                            ld_data = pad_word(i_data_word, cnt);
                            n_kind  = fill_kind;
                        end
                        if (r_pos == 4'd15) begin
                            go = 1'b1;
                        end else begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                ld_we = 1'b1;
                n_pos = pos_inc;
                go    = (r_pos == 4'd15);
                unique case (r_kind)
                    K_MARK: begin
                        ld_data = MarkerWord;
                        n_kind  = fill_kind;
                    end
                    K_ZERO: begin
                        ld_data = '0;
                        n_kind  = fill_kind;
                    end
                    K_LHI: begin
                        ld_data = r_bits[63:32];
                        n_kind  = K_LLO;
                    end
                    K_LLO: begin
                        ld_data    = r_bits[31:0];
                        n_len_done = 1'b1;
                    end
                    default: ld_data = '0;
                endcase
            end
            S_RND: begin
                n_ctl.phase = r_ctl.phase + 2'd1;
                if (r_ctl.phase == PhaseRound) begin
                    n_ctl.t = r_ctl.t + 6'd1;
                    if (r_ctl.t == 6'(RoundCount - 1)) begin
                        n_ctl.active = 1'b0;
                        n_state      = S_FIN;
                    end
                end
            end
            S_FIN: begin
                for (int i = 0; i < HashWords; i++) begin
                    n_h[i] = r_h[i] + vars[i];
                end
                n_oidx = '0;
                if (r_len_done) begin
                    n_state = S_OUT;
                end else if (r_msg_end) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IN;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state    = S_IN;
                        n_h        = InitH;
                        n_bits     = '0;
                        n_pos      = '0;
                        n_msg_end  = 1'b0;
                        n_len_done = 1'b0;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
        // start of a block compression
        if (go) begin
            n_state      = S_RND;
            n_ctl.active = 1'b1;
            n_ctl.phase  = PhaseRead;
            n_ctl.t      = '0;
        end
    end

    // control and hash registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IN;
            r_kind     <= K_MARK;
            r_pos      <= '0;
            r_bits     <= '0;
            r_msg_end  <= 1'b0;
            r_len_done <= 1'b0;
            r_oidx     <= '0;
            r_ctl      <= '0;
            r_h        <= InitH;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_pos      <= n_pos;
            r_bits     <= n_bits;
            r_msg_end  <= n_msg_end;
            r_len_done <= n_len_done;
            r_oidx     <= n_oidx;
            r_ctl      <= n_ctl;
            r_h        <= n_h;
        end
    end

    // schedule memory
    sha_sched u_sched (
        .i_clk     (i_clk),
        .i_ld_we   (ld_we),
        .i_ld_addr (r_pos),
        .i_ld_data (ld_data),
        .i_ctl     (r_ctl),
        .o_w       (w)
    );

    // round datapath
    sha_round u_round (
        .i_clk  (i_clk),
        .i_init (go),
        .i_step (r_state == S_RND && r_ctl.phase == PhaseRound),
        .i_hash (r_h),
        .i_k    (RoundK[r_ctl.t]),
        .i_w    (w),
        .o_vars (vars)
    );

    // digest output
    assign o_valid        = (r_state == S_OUT);
    assign o_digest_word  = r_h[r_oidx];
    assign o_digest_index = r_oidx;
    assign o_digest_last  = (r_oidx == 3'd7);

    // checks
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && r_ctl.phase == PhaseRound && r_ctl.t == 6'(RoundCount - 1))
        |=> (r_state == S_FIN))
        else $error("compression did not end after the last round");

    a_len_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_len_done) |=> o_valid)
        else $error("digest not presented after the length block");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_last_word) |=> o_stall)
        else $error("input taken during padding");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_digest_last) |=> (r_pos == 4'd0 && r_bits == 64'd0))
        else $error("length or position not cleared after digest");

endmodule
